/* sv/sec2cal_pkg.sv */
// Shared constants, stage-enable type and month-start table for the calendar converter.
package sec2cal_pkg;

    localparam int unsigned PIPE_STAGES = 10;

    // seconds to days
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned DAY_MAGIC    = 49710;   // floor(2^25 / 675), input pre-shifted by 7

    // day number to century base (March-based years)
    localparam int unsigned DAY_MAR_2000 = 11017;   // day number of 2000-03-01
    localparam int unsigned DAY_MAR_2100 = 47541;   // day number of 2100-03-01
    localparam int unsigned DAY_OFS_1900 = 25508;   // days from 1900-03-01 to 1970-01-01
    localparam int unsigned YEAR_1900    = 1900;
    localparam int unsigned YEAR_2000    = 2000;
    localparam int unsigned YEAR_2100    = 2100;

    // weekday
    localparam int unsigned WEEKDAY_OFS   = 3;      // 1970-01-01 was a Thursday
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned WEEK_MAGIC    = 9362;   // floor(2^16 / 7)

    // four-year and five-month cycles
    localparam int unsigned DAYS_4Y       = 1461;
    localparam int unsigned DAYS_4Y_MAGIC = 179;    // floor(2^18 / 1461)
    localparam int unsigned DAYS_5MON     = 153;
    localparam int unsigned MON_MAGIC     = 13;     // floor(2^11 / 153)
    localparam int unsigned MON_IDX_JAN   = 10;     // March-based month index of January

    // time of day
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned HOUR_MAGIC    = 36;     // floor(2^13 / 225), input pre-shifted by 4
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned MIN_MAGIC     = 68;     // floor(2^10 / 15), input pre-shifted by 2

    // one load enable per pipeline stage, index 0 is the input stage
    typedef logic [PIPE_STAGES-1:0] stage_en_t;

    // first day-of-year (March-based) of each month index, (153 * m + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mon_idx);
        logic [8:0] res;
        unique case (mon_idx)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

/* sv/sec2cal_in_if.sv */
// Input channel: one seconds count per transfer.
interface sec2cal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_count;

    modport source (output valid, output seconds_count, input ready);
    modport sink   (input valid, input seconds_count, output ready);
endinterface

/* sv/sec2cal_out_if.sv */
// Output channel: one calendar date and time of day per transfer.
interface sec2cal_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day_of_month,
                    output weekday, output hour, output minute, output second,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input weekday, input hour, input minute, input second,
                    output ready);
endinterface

/* sv/sec2cal_day_split.sv */
// Stages 1-3: split the seconds count into day number and seconds of day.
module sec2cal_day_split
    import sec2cal_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [31:0] seconds_count,
    output logic [15:0] day,
    output logic [16:0] tod
);

    logic [31:0] cnt1_reg;
    logic [40:0] prod1_reg;
    logic [40:0] prod1_next;
    logic [15:0] q0_reg;
    logic [15:0] q0_next;
    logic [17:0] tod0_reg;
    logic [17:0] tod0_next;
    logic [15:0] day_reg;
    logic [15:0] day_next;
    logic [16:0] tod_reg;
    logic [16:0] tod_next;

    logic [32:0] span;
    logic [31:0] diff;
    logic        wrap;
    logic [17:0] tod_sub;

    // estimate is floor or floor-1 of the true quotient
    assign prod1_next = 41'(seconds_count[31:7]) * 41'(DAY_MAGIC);

    assign q0_next   = prod1_reg[40:25];
    assign span      = 33'(q0_next) * 33'(SECS_PER_DAY);
    assign diff      = cnt1_reg - span[31:0];
    assign tod0_next = diff[17:0];

    assign wrap     = (tod0_reg >= 18'(SECS_PER_DAY));
    assign tod_sub  = tod0_reg - 18'(SECS_PER_DAY);
    assign day_next = q0_reg + 16'(wrap);
    assign tod_next = wrap ? tod_sub[16:0] : tod0_reg[16:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cnt1_reg  <= seconds_count;
            prod1_reg <= prod1_next;
        end
        if (en[1])
        begin
            q0_reg   <= q0_next;
            tod0_reg <= tod0_next;
        end
        if (en[2])
        begin
            day_reg <= day_next;
            tod_reg <= tod_next;
        end
    end

    assign day = day_reg;
    assign tod = tod_reg;

endmodule

/* sv/sec2cal_date.sv */
// Stages 4-10: day number to year, month, day of month and weekday.
module sec2cal_date
    import sec2cal_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [15:0] day,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [2:0]  weekday
);

    // stage 4
    logic [15:0] jp4_reg, jp4_next;
    logic [11:0] base4_reg, base4_next;
    logic [15:0] w4_reg, w4_next;
    logic [29:0] prodw4_reg, prodw4_next;
    // stage 5
    logic [17:0] y5_reg, y5_next;
    logic [25:0] prodc5_reg, prodc5_next;
    logic [11:0] base5_reg;
    logic [3:0]  rw5_reg, rw5_next;
    // stage 6
    logic [7:0]  c06_reg, c06_next;
    logic [11:0] rc6_reg, rc6_next;
    logic [11:0] base6_reg;
    logic [2:0]  wd6_reg, wd6_next;
    // stage 7
    logic [6:0]  c7_reg, c7_next;
    logic [8:0]  jd7_reg, jd7_next;
    logic [10:0] yn7_reg, yn7_next;
    logic [11:0] base7_reg;
    logic [2:0]  wd7_reg;
    // stage 8
    logic [14:0] prodd8_reg, prodd8_next;
    logic [10:0] yn8_reg;
    logic [8:0]  jd8_reg;
    logic [6:0]  c8_reg;
    logic [11:0] base8_reg;
    logic [2:0]  wd8_reg;
    // stage 9
    logic [3:0]  d09_reg, d09_next;
    logic [8:0]  rd9_reg, rd9_next;
    logic [8:0]  jd9_reg;
    logic [6:0]  c9_reg;
    logic [11:0] base9_reg;
    logic [2:0]  wd9_reg;
    // stage 10
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  mday_reg, mday_next;
    logic [2:0]  wd10_reg;

    logic [13:0] qw;
    logic [15:0] wdiff;
    logic [17:0] cdiff;
    logic        c_wrap;
    logic [11:0] rem4y;
    logic [10:0] jd_x;
    logic [10:0] ddiff;
    logic        d_wrap;
    logic [3:0]  mon_idx;
    logic        jan_feb;
    logic [8:0]  mday_0;

    // stage 4: century base and day within it, weekday product
    always_comb
    begin
        priority if (day >= 16'(DAY_MAR_2100))
        begin
            jp4_next   = day - 16'(DAY_MAR_2100);
            base4_next = 12'(YEAR_2100);
        end
        else if (day >= 16'(DAY_MAR_2000))
        begin
            jp4_next   = day - 16'(DAY_MAR_2000);
            base4_next = 12'(YEAR_2000);
        end
        else
        begin
            jp4_next   = day + 16'(DAY_OFS_1900);
            base4_next = 12'(YEAR_1900);
        end
    end

    assign w4_next     = day + 16'(WEEKDAY_OFS);
    assign prodw4_next = 30'(w4_next) * 30'(WEEK_MAGIC);

    // stage 5: four-year cycle estimate, weekday remainder
    assign y5_next     = {jp4_reg, 2'b11};
    assign prodc5_next = 26'(y5_next) * 26'(DAYS_4Y_MAGIC);
    assign qw          = prodw4_reg[29:16];
    assign wdiff       = w4_reg - 16'(qw) * 16'(DAYS_PER_WEEK);
    assign rw5_next    = wdiff[3:0];

    // stage 6
    assign c06_next = prodc5_reg[25:18];
    assign cdiff    = y5_reg - 18'(c06_next) * 18'(DAYS_4Y);
    assign rc6_next = cdiff[11:0];
    assign wd6_next = (rw5_reg >= 4'(DAYS_PER_WEEK)) ? 3'(rw5_reg - 4'(DAYS_PER_WEEK))
                                                     : rw5_reg[2:0];

    // stage 7: day of March-based year is the 4-year remainder over 4
    assign c_wrap   = (rc6_reg >= 12'(DAYS_4Y));
    assign c7_next  = 7'(c06_reg + 8'(c_wrap));
    assign rem4y    = c_wrap ? (rc6_reg - 12'(DAYS_4Y)) : rc6_reg;
    assign jd7_next = rem4y[10:2];
    assign jd_x     = 11'(jd7_next);
    assign yn7_next = (jd_x << 2) + jd_x + 11'd2;

    // stage 8
    assign prodd8_next = 15'(yn7_reg) * 15'(MON_MAGIC);

    // stage 9
    assign d09_next = prodd8_reg[14:11];
    assign ddiff    = yn8_reg - 11'(d09_next) * 11'(DAYS_5MON);
    assign rd9_next = ddiff[8:0];

    // stage 10: final month index and assembly
    assign d_wrap     = (rd9_reg >= 9'(DAYS_5MON));
    assign mon_idx    = d09_reg + 4'(d_wrap);
    assign jan_feb    = (mon_idx >= 4'(MON_IDX_JAN));
    assign mday_0     = jd9_reg - month_start(mon_idx);
    assign mday_next  = 5'(mday_0 + 9'd1);
    assign month_next = jan_feb ? (mon_idx - 4'd9) : (mon_idx + 4'd3);
    assign year_next  = base9_reg + 12'(c9_reg) + 12'(jan_feb);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            jp4_reg    <= jp4_next;
            base4_reg  <= base4_next;
            w4_reg     <= w4_next;
            prodw4_reg <= prodw4_next;
        end
        if (en[4])
        begin
            y5_reg     <= y5_next;
            prodc5_reg <= prodc5_next;
            base5_reg  <= base4_reg;
            rw5_reg    <= rw5_next;
        end
        if (en[5])
        begin
            c06_reg   <= c06_next;
            rc6_reg   <= rc6_next;
            base6_reg <= base5_reg;
            wd6_reg   <= wd6_next;
        end
        if (en[6])
        begin
            c7_reg    <= c7_next;
            jd7_reg   <= jd7_next;
            yn7_reg   <= yn7_next;
            base7_reg <= base6_reg;
            wd7_reg   <= wd6_reg;
        end
        if (en[7])
        begin
            prodd8_reg <= prodd8_next;
            yn8_reg    <= yn7_reg;
            jd8_reg    <= jd7_reg;
            c8_reg     <= c7_reg;
            base8_reg  <= base7_reg;
            wd8_reg    <= wd7_reg;
        end
        if (en[8])
        begin
            d09_reg   <= d09_next;
            rd9_reg   <= rd9_next;
            jd9_reg   <= jd8_reg;
            c9_reg    <= c8_reg;
            base9_reg <= base8_reg;
            wd9_reg   <= wd8_reg;
        end
        if (en[9])
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            mday_reg  <= mday_next;
            wd10_reg  <= wd9_reg;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;
    assign weekday      = wd10_reg;

endmodule

/* sv/sec2cal_clock.sv */
// Stages 4-10: seconds of day to hour, minute and second.
module sec2cal_clock
    import sec2cal_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [16:0] tod,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic [16:0] tod4_reg;
    logic [17:0] prodh4_reg, prodh4_next;
    logic [4:0]  h05_reg, h05_next;
    logic [12:0] rh5_reg, rh5_next;
    logic [4:0]  h6_reg, h6_next;
    logic [11:0] r6_reg, r6_next;
    logic [4:0]  h7_reg;
    logic [11:0] r7_reg;
    logic [15:0] prodm7_reg, prodm7_next;
    logic [4:0]  h8_reg;
    logic [5:0]  m08_reg, m08_next;
    logic [6:0]  rm8_reg, rm8_next;
    logic [4:0]  h9_reg;
    logic [5:0]  m9_reg, m9_next;
    logic [5:0]  s9_reg, s9_next;
    logic [4:0]  h10_reg;
    logic [5:0]  m10_reg;
    logic [5:0]  s10_reg;

    logic [16:0] hdiff;
    logic        h_wrap;
    logic [12:0] rh_sub;
    logic [11:0] mdiff;
    logic        m_wrap;
    logic [6:0]  rm_sub;

    assign prodh4_next = 18'(tod[16:4]) * 18'(HOUR_MAGIC);

    assign h05_next = prodh4_reg[17:13];
    assign hdiff    = tod4_reg - 17'(h05_next) * 17'(SECS_PER_HOUR);
    assign rh5_next = hdiff[12:0];

    assign h_wrap  = (rh5_reg >= 13'(SECS_PER_HOUR));
    assign rh_sub  = rh5_reg - 13'(SECS_PER_HOUR);
    assign h6_next = h05_reg + 5'(h_wrap);
    assign r6_next = h_wrap ? rh_sub[11:0] : rh5_reg[11:0];

    assign prodm7_next = 16'(r6_reg[11:2]) * 16'(MIN_MAGIC);

    assign m08_next = prodm7_reg[15:10];
    assign mdiff    = r7_reg - 12'(m08_next) * 12'(SECS_PER_MIN);
    assign rm8_next = mdiff[6:0];

    assign m_wrap  = (rm8_reg >= 7'(SECS_PER_MIN));
    assign rm_sub  = rm8_reg - 7'(SECS_PER_MIN);
    assign m9_next = m08_reg + 6'(m_wrap);
    assign s9_next = m_wrap ? rm_sub[5:0] : rm8_reg[5:0];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            tod4_reg   <= tod;
            prodh4_reg <= prodh4_next;
        end
        if (en[4])
        begin
            h05_reg <= h05_next;
            rh5_reg <= rh5_next;
        end
        if (en[5])
        begin
            h6_reg <= h6_next;
            r6_reg <= r6_next;
        end
        if (en[6])
        begin
            h7_reg     <= h6_reg;
            r7_reg     <= r6_reg;
            prodm7_reg <= prodm7_next;
        end
        if (en[7])
        begin
            h8_reg  <= h7_reg;
            m08_reg <= m08_next;
            rm8_reg <= rm8_next;
        end
        if (en[8])
        begin
            h9_reg <= h8_reg;
            m9_reg <= m9_next;
            s9_reg <= s9_next;
        end
        if (en[9])
        begin
            h10_reg <= h9_reg;
            m10_reg <= m9_reg;
            s10_reg <= s9_reg;
        end
    end

    assign hour   = h10_reg;
    assign minute = m10_reg;
    assign second = s10_reg;

endmodule

/* sv/seconds_to_calendar_date.sv */
// An accepted seconds count passes through stages 1-10 to its date on the output register.
// Throughput: one transfer per cycle while the output is ready; a stall holds each full stage
//   and empty stages keep filling, so input is taken while a finished date waits at the output.
// Divisions are reciprocal multiplies with one correction step, three stages each.
// Reset: rst_n (async, active low) clears only the stage valid bits; the datapath
//   registers are not reset.
module seconds_to_calendar_date
    import sec2cal_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sec2cal_in_if.sink     stamp,
    sec2cal_out_if.source  calendar
);

    // Stage map:
    //   1-3  seconds -> day number + seconds of day (sec2cal_day_split)
    //   4-10 day number -> date and weekday (sec2cal_date)
    //   4-10 seconds of day -> hh:mm:ss     (sec2cal_clock)
    // Stage 10 is the output register.

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    stage_en_t              stage_en;

    logic [15:0] day;
    logic [16:0] tod;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || calendar.ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            if (stage_en[i])
            begin
                valid_next[i] = (i == 0) ? stamp.valid : valid_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign stamp.ready    = stage_en[0];
    assign calendar.valid = valid_reg[PIPE_STAGES-1];

    sec2cal_day_split u_day_split (
        .clk           (clk),
        .en            (stage_en),
        .seconds_count (stamp.seconds_count),
        .day           (day),
        .tod           (tod)
    );

    sec2cal_date u_date (
        .clk          (clk),
        .en           (stage_en),
        .day          (day),
        .year         (calendar.year),
        .month        (calendar.month),
        .day_of_month (calendar.day_of_month),
        .weekday      (calendar.weekday)
    );

    sec2cal_clock u_clock (
        .clk    (clk),
        .en     (stage_en),
        .tod    (tod),
        .hour   (calendar.hour),
        .minute (calendar.minute),
        .second (calendar.second)
    );

`ifndef SYNTHESIS
    // An open output never blocks the input side.
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        calendar.ready |-> stamp.ready)
        else $error("input stalled while output is ready");

    // Results stay inside the calendar that a 32-bit count can reach.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        calendar.valid |-> (calendar.year >= 12'd1970 && calendar.year <= 12'd2106
                            && calendar.month >= 4'd1 && calendar.month <= 4'd12
                            && calendar.day_of_month >= 5'd1 && calendar.weekday <= 3'd6))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        calendar.valid |-> (calendar.hour <= 5'd23 && calendar.minute <= 6'd59
                            && calendar.second <= 6'd59))
        else $error("time field out of range");

    // An accepted count reaches stage 1 on the next edge.
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp.valid && stamp.ready) |=> valid_reg[0])
        else $error("accepted transfer lost at the input stage");
`endif

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the seconds-to-calendar-date pipeline.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Calendar arithmetic constants (Julian day route to the civil date)
    // ------------------------------------------------------------------
    localparam longint unsigned DAY_SECS    = 86400;
    localparam longint unsigned HALF_DAY    = 43200;
    localparam longint unsigned JDN_EPOCH_H = 2440587;  // Julian date of 1970-01-01 00:00, rounded down
    localparam longint unsigned JDN_BIAS    = 32044;
    localparam longint unsigned ERA_DAYS    = 146097;   // days in 400 years
    localparam longint unsigned QUAD_DAYS   = 1461;     // days in 4 years
    localparam longint unsigned FIVE_MONTHS = 153;
    localparam longint unsigned YEAR_BIAS   = 4800;
    localparam longint unsigned HOUR_SECS   = 3600;
    localparam longint unsigned MIN_SECS    = 60;

    localparam int RANDOM_STAMPS  = 1700;
    localparam int MAX_GAP        = 16;
    localparam int PIPE_LATENCY   = 10;
    localparam int SETTLE_CYCLES  = 4 * PIPE_LATENCY;
    localparam int LONG_HOLD      = 400;       // receiver hold-off, well past pipe depth
    localparam int HOLD_COUNT     = 2;
    localparam int HOLD_SPACING   = 800;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    typedef struct {
        logic [31:0] secs;
        int          gap;          // idle cycles before this stamp is offered
        bit          drain_first;  // hold back until every date is out
    } stamp_item_t;

    logic clk;
    logic rst_n;

    sec2cal_in_if  stamp_if ();
    sec2cal_out_if cal_if ();

    seconds_to_calendar_date i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .stamp    (stamp_if),
        .calendar (cal_if)
    );

    stamp_item_t pending_stamps[$];
    calendar_t   calendar_due[$];

    int  stamps_taken  = 0;
    int  dates_seen    = 0;
    int  mismatch_cnt  = 0;
    int  cycle_cnt     = 0;
    int  hold_left     = 0;
    int  holds_done    = 0;
    bit  stamp_loaded  = 0;

    // ------------------------------------------------------------------
    // Predictor: seconds -> Julian day (half-day rounding) -> civil date.
    // Everything is kept in 64 bits, so the top of the 32-bit range
    // cannot wrap during the rounding step.
    // ------------------------------------------------------------------
    function automatic calendar_t civil_from_seconds(input logic [31:0] secs);
        longint unsigned cnt, tod, jdn, era, quad, mi;
        calendar_t       cal;
        cnt = secs;
        tod = cnt % DAY_SECS;
        jdn = ((cnt + HALF_DAY) / HALF_DAY + (JDN_EPOCH_H << 1) + 1) >> 1;
        cal.weekday = 3'(jdn % 7);      // JDN mod 7: 0 is Monday
        jdn  = jdn + JDN_BIAS;
        era  = (4 * jdn + 3) / ERA_DAYS;
        jdn  = jdn - (ERA_DAYS * era) / 4;
        quad = (4 * jdn + 3) / QUAD_DAYS;
        jdn  = jdn - (QUAD_DAYS * quad) / 4;
        mi   = (5 * jdn + 2) / FIVE_MONTHS;   // March-based month index
        cal.day_of_month = 5'(jdn - (FIVE_MONTHS * mi + 2) / 5 + 1);
        cal.month        = 4'(mi + 3 - 12 * (mi / 10));
        cal.year         = 12'(100 * era + quad + mi / 10 - YEAR_BIAS);
        cal.hour         = 5'(tod / HOUR_SECS);
        cal.minute       = 6'((tod % HOUR_SECS) / MIN_SECS);
        cal.second       = 6'(tod % MIN_SECS);
        return cal;
    endfunction

    // ------------------------------------------------------------------
    // Clock and the single reset at time zero
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        // every input known from the first instant
        rst_n                  = 1'b0;
        stamp_if.valid         = 1'b0;
        stamp_if.seconds_count = '0;
        cal_if.ready           = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued stamps, holds valid until the transfer,
    // then waits out the next item's gap (or the drain request).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : stamp_driver
        stamp_item_t cur;
        int          gap_left;
        bit          nxt_valid;
        bit          taken;
        if (rst_n)
        begin
            taken = stamp_if.valid && stamp_if.ready;
            if (taken)
            begin
                calendar_due.push_back(civil_from_seconds(stamp_if.seconds_count));
                stamps_taken++;
            end
            nxt_valid = stamp_if.valid && !taken;
            if (!nxt_valid)
            begin
                if (!stamp_loaded && pending_stamps.size() > 0)
                begin
                    cur          = pending_stamps.pop_front();
                    gap_left     = cur.gap;
                    stamp_loaded = 1'b1;
                end
                if (stamp_loaded)
                begin
                    if (cur.drain_first && calendar_due.size() != 0)
                        nxt_valid = 1'b0;
                    else if (gap_left > 0)
                        gap_left--;
                    else
                    begin
                        nxt_valid    = 1'b1;
                        stamp_loaded = 1'b0;
                        stamp_if.seconds_count <= cur.secs;
                    end
                end
            end
            stamp_if.valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here: the sender keeps offering,
    // so the pipe fills up and must push back on its input.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (holds_done < HOLD_COUNT
                     && stamps_taken >= 300 + holds_done * HOLD_SPACING)
            begin
                hold_left  <= LONG_HOLD;
                holds_done <= holds_done + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each date transfer against the oldest prediction
    // and draws its own stall before taking the next one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : date_monitor
        calendar_t got, want;
        int        stall_left;
        bit        nxt_ready;
        if (rst_n)
        begin
            if (cal_if.valid && cal_if.ready)
            begin
                got = '{cal_if.year, cal_if.month, cal_if.day_of_month, cal_if.weekday,
                        cal_if.hour, cal_if.minute, cal_if.second};
                dates_seen++;
                if (calendar_due.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("[%0t] unexpected date %0d-%0d-%0d wd%0d %0d:%0d:%0d",
                                 $realtime, got.year, got.month, got.day_of_month,
                                 got.weekday, got.hour, got.minute, got.second);
                end
                else
                begin
                    want = calendar_due.pop_front();
                    if (got.year !== want.year || got.month !== want.month
                        || got.day_of_month !== want.day_of_month
                        || got.weekday !== want.weekday || got.hour !== want.hour
                        || got.minute !== want.minute || got.second !== want.second)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display("[%0t] date #%0d exp %0d-%0d-%0d wd%0d %0d:%0d:%0d",
                                     $realtime, dates_seen, want.year, want.month,
                                     want.day_of_month, want.weekday, want.hour,
                                     want.minute, want.second,
                                     " got %0d-%0d-%0d wd%0d %0d:%0d:%0d",
                                     got.year, got.month, got.day_of_month,
                                     got.weekday, got.hour, got.minute, got.second);
                    end
                end
                // every third block of 150 dates runs with no stalls at all
                if ((dates_seen / 150) % 3 == 0 || $urandom_range(0, 2) != 0)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, MAX_GAP);
            end
            if (hold_left > 0)
                nxt_ready = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            cal_if.ready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout: %0d dates still due", calendar_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed corners, then random stamps
    // ------------------------------------------------------------------
    function automatic int draw_gap(input int idx);
        // runs of back-to-back transfers, otherwise occasional gaps up to the max
        if ((idx / 100) % 4 == 1)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, MAX_GAP);
        return 0;
    endfunction

    initial
    begin : stimulus
        logic [31:0]     corner[$];
        logic [31:0]     secs;
        longint unsigned day_no, offs;
        stamp_item_t     item;
        int              kind;

        corner = '{32'd0,              // epoch, Thursday
                   32'hFFFF_FFFF,      // top of range, 2106-02-07 Sunday
                   32'd43199, 32'd43200, 32'd86399, 32'd86400,   // half-day and day edges
                   32'd68169599,       // 1972-02-28 23:59:59
                   32'd68256000,       // 1972-03-01, after a leap day
                   32'd946684799,      // last second of 1999
                   32'd946684800,      // 2000-01-01
                   32'd951782400,      // 2000-02-29, century leap year
                   32'd951868800,      // 2000-03-01
                   32'd2147483647, 32'd2147483648,
                   32'd4102444800,     // 2100-01-01
                   32'd4107456000,     // 2100-02-28, no leap day in 2100
                   32'd4107542400,     // 2100-03-01
                   32'd4294944000,     // start of the last day in range
                   32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corner[i])
        begin
            item = '{corner[i], (i % 3 == 2) ? MAX_GAP : 0, 1'b0};
            pending_stamps.push_back(item);
        end

        for (int i = 0; i < RANDOM_STAMPS; i++)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0, 1:
                    secs = $urandom();
                2:
                begin
                    // just around midnight or noon on a random day
                    day_no = $urandom_range(0, 49709);
                    case ($urandom_range(0, 5))
                        0: offs = 0;
                        1: offs = 1;
                        2: offs = HALF_DAY - 1;
                        3: offs = HALF_DAY;
                        4: offs = DAY_SECS - 2;
                        default: offs = DAY_SECS - 1;
                    endcase
                    secs = 32'(day_no * DAY_SECS + offs);
                end
                default:
                    secs = 32'hFFFF_FFFF - $urandom_range(0, 200000);   // near the top
            endcase
            item = '{secs, draw_gap(i), (i == 0 || i == RANDOM_STAMPS / 2)};
            pending_stamps.push_back(item);
        end

        @(posedge rst_n);
        while (pending_stamps.size() != 0 || stamp_loaded || stamp_if.valid)
            @(posedge clk);
        while (calendar_due.size() != 0)
            @(posedge clk);
        // catch any stray date after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
